@@ sv/vkr_pkg.sv @@
// ----------------------------------------------------------------------------
// vkr_pkg
// Shared types, constants and helpers for the verb key registry.
// ----------------------------------------------------------------------------
package vkr_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int KEY_W     = 32;
	localparam int LEN_W     = 8;
	localparam int HANDLER_W = 64;
	localparam int ECOUNT_W  = 6;
	localparam int MAX_LEN   = 4;

	// stream layout
	localparam int S_TDATA_W = 104;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 72;
	localparam int M_TUSER_W = 2;

	localparam int S_KEY_LSB     = 0;
	localparam int S_LEN_LSB     = S_KEY_LSB + KEY_W;
	localparam int S_HANDLER_LSB = S_LEN_LSB + LEN_W;
	localparam int M_HANDLER_LSB = 0;
	localparam int M_ECOUNT_LSB  = M_HANDLER_LSB + HANDLER_W;

	typedef enum logic [0:0] {
		CMD_REGISTER = 1'b0,
		CMD_LOOKUP   = 1'b1
	} vkr_cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISS    = 2'd3
	} vkr_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESOLVE
	} vkr_state_t;

	// keep only the low len bytes of the raw key (the whole key when len is 0 or above 4)
	function automatic logic [KEY_W-1:0] form_key(input logic [KEY_W-1:0] raw,
			input logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] mask;
		begin
			unique case (len)
				8'd1:    mask = 32'h0000_00FF;
				8'd2:    mask = 32'h0000_FFFF;
				8'd3:    mask = 32'h00FF_FFFF;
				default: mask = 32'hFFFF_FFFF;
			endcase
			form_key = raw & mask;
		end
	endfunction

	// saturate the held count into the result field
	function automatic logic [ECOUNT_W-1:0] sat_count(input logic [CNT_W:0] cnt);
		begin
			if (int'(cnt) > 63)
				sat_count = 6'd63;
			else
				sat_count = ECOUNT_W'(cnt);
		end
	endfunction

endpackage

@@ sv/vkr_ram.sv @@
// ----------------------------------------------------------------------------
// vkr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module vkr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ sv/verb_key_registry.sv @@
// ----------------------------------------------------------------------------
// verb_key_registry
// Associative table binding packed name keys to 64-bit handler words.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser
//  s_*     | in  | key_bytes, name_length, handler_word        | command
//  m_*     | out | found_handler, entry_count, zero pad        | status
//
//  A rejected item skips the scan; any other item scans the held entries,
//  one RAM read a cycle until a match or the end (no read with the table
//  empty), then resolves the result and writes back.
//  Reset clears the entry count and control state; RAM contents stay undefined.
//  s_tready drops for the whole item; a finished word waits in the output
//  register, and the next item waits in resolve while that word stalls.
// ----------------------------------------------------------------------------
module verb_key_registry
	import vkr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // key_bytes[31:0], name_length[39:32], handler_word[103:40]
	input  logic [S_TUSER_W-1:0] s_tuser,  // command[0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // found_handler[63:0], entry_count[69:64], zero[71:70]
	output logic [M_TUSER_W-1:0] m_tuser   // status[1:0]
);

	vkr_state_t state_q, state_d;

	logic [0:0]           cmd_q;
	logic [KEY_W-1:0]     key_q;
	logic [HANDLER_W-1:0] handler_q;
	logic                 invalid_q;
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [HANDLER_W-1:0] hit_handler_q;
	logic [CNT_W-1:0]     issue_idx_q;
	logic [CNT_W-1:0]     count_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	logic [KEY_W-1:0]     raw_key;
	logic [LEN_W-1:0]     raw_len;
	logic [HANDLER_W-1:0] raw_handler;
	logic [KEY_W-1:0]     formed_key;
	logic                 accept;

	logic [KEY_W-1:0]     key_rd;
	logic [HANDLER_W-1:0] hdl_rd;
	logic                 match;
	logic                 issue;
	logic                 out_free;
	logic                 load_out;
	logic                 append;
	logic                 rebind;
	logic                 key_we;
	logic                 hdl_we;
	logic [IDX_W-1:0]     wr_idx;
	vkr_status_t          res_status;
	logic [HANDLER_W-1:0] res_found;
	logic [CNT_W:0]       count_next;

	assign raw_key     = s_tdata[S_KEY_LSB +: KEY_W];
	assign raw_len     = s_tdata[S_LEN_LSB +: LEN_W];
	assign raw_handler = s_tdata[S_HANDLER_LSB +: HANDLER_W];
	assign formed_key  = form_key(raw_key, raw_len);
	assign accept      = s_tvalid && s_tready;

	assign match    = rd_vld_s1 && (key_rd == key_q);
	assign out_free = !m_tvalid_q || m_tready;

	// reads happen only while scanning and writes only while resolving,
	// so the state machine itself keeps the two apart
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		issue      = 1'b0;
		load_out   = 1'b0;
		append     = 1'b0;
		rebind     = 1'b0;
		res_status = ST_OK;
		res_found  = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser[0] == CMD_REGISTER &&
							(raw_len == '0 || int'(raw_len) > MAX_LEN ||
							formed_key == '0 || raw_handler == '0))
						state_d = S_RESOLVE;
					else
						state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				issue = (issue_idx_q < count_q) && !match;
				if (match || (!rd_vld_s1 && !issue))
					state_d = S_RESOLVE;
			end
			S_RESOLVE: begin
				priority if (invalid_q) begin
					res_status = ST_INVALID;
				end else if (cmd_q == CMD_LOOKUP) begin
					if (hit_q)
						res_found = hit_handler_q;
					else
						res_status = ST_MISS;
				end else if (hit_q) begin
					rebind = 1'b1;
				end else if (int'(count_q) >= TABLE_ENTRIES) begin
					res_status = ST_FULL;
				end else begin
					append = 1'b1;
				end
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign key_we     = append && load_out;
	assign hdl_we     = (append || rebind) && load_out;
	assign wr_idx     = append ? count_q[IDX_W-1:0] : hit_idx_q;
	assign count_next = {1'b0, count_q} + (CNT_W+1)'(append);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (accept)
				hit_q <= 1'b0;
			else if (state_q == S_SCAN && match)
				hit_q <= 1'b1;
			if (key_we)
				count_q <= count_q + CNT_W'(1);
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= s_tuser[0];
			key_q       <= (s_tuser[0] == CMD_LOOKUP) ? raw_key : formed_key;
			handler_q   <= raw_handler;
			invalid_q   <= (s_tuser[0] == CMD_REGISTER) &&
				(raw_len == '0 || int'(raw_len) > MAX_LEN ||
				formed_key == '0 || raw_handler == '0);
			issue_idx_q <= '0;
		end else if (issue) begin
			issue_idx_q <= issue_idx_q + CNT_W'(1);
		end
		rd_idx_s1 <= issue_idx_q[IDX_W-1:0];
		if (state_q == S_SCAN && match) begin
			hit_idx_q     <= rd_idx_s1;
			hit_handler_q <= hdl_rd;
		end
		if (load_out) begin
			m_tdata_q <= {{(M_TDATA_W - HANDLER_W - ECOUNT_W){1'b0}},
				sat_count(count_next), res_found};
			m_tuser_q <= res_status;
		end
	end

	vkr_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (wr_idx),
		.wdata (key_q),
		.re    (issue),
		.raddr (issue_idx_q[IDX_W-1:0]),
		.rdata (key_rd)
	);

	vkr_ram #(
		.WIDTH(HANDLER_W),
		.DEPTH(TABLE_ENTRIES)
	) u_hdl_ram (
		.clk   (clk),
		.we    (hdl_we),
		.waddr (wr_idx),
		.wdata (handler_q),
		.re    (issue),
		.raddr (issue_idx_q[IDX_W-1:0]),
		.rdata (hdl_rd)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ sv/vkr_checker.sv @@
// ----------------------------------------------------------------------------
// vkr_checker
// Port-level checks for the verb key registry, bound to the top level.
// ----------------------------------------------------------------------------
module vkr_checker
	import vkr_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one item at a time: input stalls straight after a take
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// only a hit carries a handler
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[M_HANDLER_LSB +: HANDLER_W] == '0)
		else $error("handler returned with a failing status");

	// count never goes beyond the table
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> int'(m_tdata[M_ECOUNT_LSB +: ECOUNT_W]) <= TABLE_ENTRIES)
		else $error("entry count beyond table size");

	// a returned handler only comes from a non-empty table
	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OK && m_tdata[M_HANDLER_LSB +: HANDLER_W] != '0
		|-> m_tdata[M_ECOUNT_LSB +: ECOUNT_W] != '0)
		else $error("handler returned from an empty table");

endmodule

bind verb_key_registry vkr_checker u_vkr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
